[hw/rtl/otp_pkg.sv]
// Shared types, codes and constants of the one-shot timer pool.
package otp_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int SLOT_W          = 3;
  localparam int TICK_W          = 16;
  localparam int TAG_W           = 16;
  localparam int ID_W            = 8;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_STOPPED = 3'd2;
  localparam logic [2:0] KIND_BAD_ID  = 3'd3;
  localparam logic [2:0] KIND_EXPIRED = 3'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [TICK_W-1:0] delay_ticks;
    logic              deferred;
    logic [TAG_W-1:0]  handler_tag;
    logic [ID_W-1:0]   slot_id;
  } otp_req_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag_out;
    logic              deferred_out;
    logic              last;
  } otp_rsp_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [TICK_W-1:0] delay;
    logic              deferred;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
  } otp_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } otp_qctl_t;

  typedef struct packed {
    logic full;
    logic valid;
  } otp_qsts_t;

endpackage

[hw/rtl/otp_front.sv]
// Request intake: classify requests into commands for the command queue.
module otp_front import otp_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic      req_valid,
  output logic      req_stall,
  input  otp_req_t  req,
  input  otp_qsts_t qsts,
  output logic      push,
  output otp_cmd_t  cmd
);

  logic keep;

  assign req_stall = qsts.full;

  always_comb begin
    keep         = 1'b1;
    cmd.delay    = req.delay_ticks;
    cmd.deferred = req.deferred;
    cmd.tag      = req.handler_tag;
    cmd.slot     = req.slot_id[SLOT_W-1:0];
    case (req.action)
      ACT_TICK:  cmd.op = OP_TICK;
      ACT_START: cmd.op = OP_START;
      ACT_STOP: begin
        if (req.slot_id < ID_W'(TIMER_SLOTS)) begin
          cmd.op = OP_STOP;
        end else begin
          cmd.op = OP_BAD;
        end
      end
      default: begin
        cmd.op = OP_TICK;
        keep   = 1'b0;
      end
    endcase
  end

  assign push = req_valid && !qsts.full && keep;

endmodule

[hw/rtl/otp_queue.sv]
// Two-entry command queue between intake and timer engine.
module otp_queue import otp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  otp_qctl_t qctl,
  input  otp_cmd_t  wr_cmd,
  output otp_qsts_t qsts,
  output otp_cmd_t  rd_cmd
);

  otp_cmd_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign qsts.full  = (count == 2'd2);
  assign qsts.valid = (count != 2'd0);
  assign rd_cmd     = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (qctl.push && !qctl.pop) begin
      count_next = count + 2'd1;
    end else if (!qctl.push && qctl.pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (qctl.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (qctl.pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.push) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

endmodule

[hw/rtl/otp_back.sv]
// Timer engine: slot state, tick update, expiry walk and response register.
module otp_back import otp_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  otp_qsts_t qsts,
  input  otp_cmd_t  cmd,
  output logic      pop,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output otp_rsp_t  rsp
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                   state;
  logic [TIMER_SLOTS-1:0] active;
  logic [TIMER_SLOTS-1:0] pending;
  logic [TIMER_SLOTS-1:0] mode;
  logic [TICK_W-1:0]      remaining [TIMER_SLOTS];
  logic [TAG_W-1:0]       tags      [TIMER_SLOTS];

  logic                   can_load;
  logic                   do_tick;
  logic                   do_start;
  logic                   do_stop;
  logic                   do_bad;
  logic                   do_emit;
  logic [TIMER_SLOTS-1:0] expire;
  logic [TIMER_SLOTS-1:0] free_mask;
  logic                   any_free;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       pend_idx;
  logic                   pend_last;
  logic [IDX_W-1:0]       stop_idx;

  assign can_load = !rsp_valid || !rsp_stall;
  assign pop      = (state == ST_IDLE) && qsts.valid && can_load;
  assign do_tick  = pop && (cmd.op == OP_TICK);
  assign do_start = pop && (cmd.op == OP_START);
  assign do_stop  = pop && (cmd.op == OP_STOP);
  assign do_bad   = pop && (cmd.op == OP_BAD);
  assign do_emit  = (state == ST_EMIT) && can_load;
  assign stop_idx = cmd.slot[IDX_W-1:0];

  assign free_mask = ~active;
  assign any_free  = |free_mask;
  assign pend_last = ((pending & (pending - TIMER_SLOTS'(1))) == '0);

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      expire[i] = active[i] && (remaining[i] == TICK_W'(1));
    end
  end

  always_comb begin
    free_idx = '0;
    pend_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = IDX_W'(i);
      end
      if (pending[i]) begin
        pend_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= '0;
      pending   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (do_tick) begin
        active  <= active & ~expire;
        pending <= expire;
        if (|expire) begin
          state <= ST_EMIT;
        end
      end
      if (do_start && any_free) begin
        active[free_idx] <= 1'b1;
      end
      if (do_stop) begin
        active[stop_idx] <= 1'b0;
      end
      if (do_start || do_stop || do_bad || do_emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (do_emit) begin
        pending[pend_idx] <= 1'b0;
        if (pend_last) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (active[i]) begin
          remaining[i] <= remaining[i] - TICK_W'(1);
        end
      end
    end
    if (do_start && any_free) begin
      remaining[free_idx] <= cmd.delay;
      tags[free_idx]      <= cmd.tag;
      mode[free_idx]      <= cmd.deferred;
    end
    if (do_start) begin
      rsp.kind         <= any_free ? KIND_STARTED : KIND_FULL;
      rsp.slot         <= any_free ? SLOT_W'(free_idx) : '0;
      rsp.tag_out      <= '0;
      rsp.deferred_out <= 1'b0;
      rsp.last         <= 1'b1;
    end else if (do_stop) begin
      rsp.kind         <= KIND_STOPPED;
      rsp.slot         <= SLOT_W'(stop_idx);
      rsp.tag_out      <= '0;
      rsp.deferred_out <= 1'b0;
      rsp.last         <= 1'b1;
    end else if (do_bad) begin
      rsp.kind         <= KIND_BAD_ID;
      rsp.slot         <= '0;
      rsp.tag_out      <= '0;
      rsp.deferred_out <= 1'b0;
      rsp.last         <= 1'b1;
    end else if (do_emit) begin
      rsp.kind         <= KIND_EXPIRED;
      rsp.slot         <= SLOT_W'(pend_idx);
      rsp.tag_out      <= tags[pend_idx];
      rsp.deferred_out <= mode[pend_idx];
      rsp.last         <= pend_last;
    end
  end

  a_pending_inactive: assert property (@(posedge clk) disable iff (rst)
    (pending & active) == '0)
    else $error("expiring slot still marked active");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pending == '0))
    else $error("expiries left behind in idle");

  a_more_expiries: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.kind == KIND_EXPIRED) && !rsp.last) |-> (state == ST_EMIT))
    else $error("non-final expiry without a walk in progress");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (pending != '0))
    else $error("expiry walk with nothing pending");

endmodule

[hw/rtl/oneshot_timer_pool.sv]
// Top level of the one-shot timer pool.
//
//   channel   signals                      direction
//   request   req_valid, req_stall, req    into the pool
//   response  rsp_valid, rsp_stall, rsp    out of the pool
//
// Start and stop: response registered when the engine takes the command
// from the queue. Tick: all slots update together, then one expiry response
// per cycle while the response is not stalled.
// A two-entry command queue lets requests transfer while the engine waits.
// rst is synchronous; the slot delay and tag storage is not cleared.
// A stalled response holds the engine; a full queue stalls requests.
module oneshot_timer_pool import otp_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  otp_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output otp_rsp_t rsp
);

  otp_qctl_t qctl;
  otp_qsts_t qsts;
  otp_cmd_t  wr_cmd;
  otp_cmd_t  rd_cmd;
  logic      q_push;
  logic      q_pop;

  assign qctl = '{push: q_push, pop: q_pop};

  otp_front #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .qsts      (qsts),
    .push      (q_push),
    .cmd       (wr_cmd)
  );

  otp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .qctl   (qctl),
    .wr_cmd (wr_cmd),
    .qsts   (qsts),
    .rd_cmd (rd_cmd)
  );

  otp_back #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qsts      (qsts),
    .cmd       (rd_cmd),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
